[hw/rtl/dktr_pkg.sv]
// shared constants and types for the debounced key toggle relay driver
`default_nettype none

package dktr_pkg;

  // fixed field widths of the channels
  localparam int unsigned KEY_W      = 10;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned WORD_OUT_W = 16;

  // reset value of the debounce period register
  localparam logic [HOLD_W-1:0] PERIOD_RST = HOLD_W'(1);

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/dktr_intf.sv]
// valid/ready channel interfaces for key beats and serial result beats
`default_nettype none

interface dktr_in_if import dktr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             load_valid;
  logic [BYTE_W-1:0] load_high;
  logic [BYTE_W-1:0] load_low;
  logic [KEY_W-1:0]  keys_first;
  logic [KEY_W-1:0]  keys_confirm;
  logic [KEY_W-1:0]  keys_final;

  modport source (
    output valid, load_valid, load_high, load_low, keys_first, keys_confirm, keys_final,
    input  ready
  );
  modport sink (
    input  valid, load_valid, load_high, load_low, keys_first, keys_confirm, keys_final,
    output ready
  );
endinterface

interface dktr_out_if import dktr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  serial_bit;
  logic                  latch_last;
  logic [WORD_OUT_W-1:0] relay_word;

  modport source (
    output valid, serial_bit, latch_last, relay_word,
    input  ready
  );
  modport sink (
    input  valid, serial_bit, latch_last, relay_word,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/debounced_key_toggle_relay_driver_top.sv]
// top level of the debounced key toggle relay driver
//
//  channel  dir  handshake      payload
//  key_i    in   valid/ready    load_valid, load_high, load_low, keys_first/confirm/final
//  bit_o    out  valid/ready    serial_bit, latch_last, relay_word
//  cfg      in   cfg_we_i       cfg_wdata_i = debounce_period
//
// A key beat is taken by the front part; its relay word waits in a two-entry
// queue. The back part sends RELAY_BITS result beats per key beat, one per cycle
// while bit_o.ready is high, so the serializer sets the sustained rate. Reset is
// asynchronous, active low: relay word 0, released set, period 1. A stall on bit_o
// fills the queue, then key_i.ready drops.
`default_nettype none

module debounced_key_toggle_relay_driver_top import dktr_pkg::*; #(
  parameter int unsigned KEY_COUNT  = 10,
  parameter int unsigned RELAY_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [HOLD_W-1:0] cfg_wdata_i,
  dktr_in_if.sink                key_i,
  dktr_out_if.source             bit_o
);

  logic                  push;
  logic [RELAY_BITS-1:0] push_word;
  logic                  pop;
  logic [RELAY_BITS-1:0] pop_word;
  q_stat_t               q_stat;

  // tick processing
  dktr_front #(
    .KEY_COUNT  (KEY_COUNT),
    .RELAY_BITS (RELAY_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_i       (key_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_word_o (push_word)
  );

  // decoupling queue
  dktr_fifo #(
    .RELAY_BITS (RELAY_BITS)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .pop_word_o  (pop_word),
    .stat_o      (q_stat)
  );

  // serial output
  dktr_back #(
    .RELAY_BITS (RELAY_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .q_word_i (pop_word),
    .pop_o    (pop),
    .bit_o    (bit_o)
  );

endmodule

`default_nettype wire

[hw/rtl/dktr_front.sv]
// front part: relay load, key arming, debounce count and toggle per tick
`default_nettype none

module dktr_front import dktr_pkg::*; #(
  parameter int unsigned KEY_COUNT  = 10,
  parameter int unsigned RELAY_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [HOLD_W-1:0]     cfg_wdata_i,
  dktr_in_if.sink                    key_i,
  input  wire q_stat_t               q_stat_i,
  output logic                       push_o,
  output logic [RELAY_BITS-1:0]      push_word_o
);

  logic [RELAY_BITS-1:0] relay_q, relay_d;
  logic                  armed_q, armed_d;
  logic                  released_q, released_d;
  logic [HOLD_W-1:0]     hold_q, hold_d;
  logic [HOLD_W-1:0]     period_q;
  logic [RELAY_BITS-1:0] first_w, confirm_w, final_w;
  logic                  take;

  // key n sits at sample bit KEY_COUNT-1-n and drives relay bit RELAY_BITS-1-n
  function automatic logic [RELAY_BITS-1:0] key_word(input logic [KEY_W-1:0] raw);
    logic [RELAY_BITS-1:0] w;
    w = '0;
    for (int n = 0; n < int'(KEY_COUNT); n++) begin
      if ((int'(KEY_COUNT) - 1 - n) < int'(KEY_W) && (int'(RELAY_BITS) - 1 - n) >= 0) begin
        w[int'(RELAY_BITS) - 1 - n] = raw[int'(KEY_COUNT) - 1 - n];
      end
    end
    return w;
  endfunction

  // two load bytes placed into the relay word, cut or widened to its size
  function automatic logic [RELAY_BITS-1:0] load_word(input logic [2*BYTE_W-1:0] v);
    logic [RELAY_BITS-1:0] w;
    w = '0;
    for (int i = 0; i < int'(RELAY_BITS); i++) begin
      if (i < int'(2*BYTE_W)) begin
        w[i] = v[i];
      end
    end
    return w;
  endfunction

  assign take        = key_i.valid && key_i.ready;
  assign key_i.ready = !q_stat_i.full;
  assign first_w     = key_word(key_i.keys_first);
  assign confirm_w   = key_word(key_i.keys_confirm);
  assign final_w     = key_word(key_i.keys_final);

  // next state for one tick
  always_comb begin
    relay_d    = relay_q;
    armed_d    = armed_q;
    released_d = released_q;
    hold_d     = hold_q;
    if (key_i.load_valid) begin
      relay_d = load_word({key_i.load_high, key_i.load_low});
    end
    if (first_w != '0) begin
      if (!armed_q && released_q) begin
        armed_d = 1'b1;
      end
    end else begin
      released_d = 1'b1;
    end
    if (armed_d && first_w == confirm_w) begin
      if (hold_q < period_q) begin
        hold_d = hold_q + HOLD_W'(1);
      end else begin
        relay_d    = relay_d ^ (first_w & final_w);
        armed_d    = 1'b0;
        released_d = 1'b0;
        hold_d     = '0;
      end
    end else begin
      armed_d = 1'b0;
    end
  end

  // state registers, updated on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q    <= '0;
      armed_q    <= 1'b0;
      released_q <= 1'b1;
      hold_q     <= '0;
    end else if (take) begin
      relay_q    <= relay_d;
      armed_q    <= armed_d;
      released_q <= released_d;
      hold_q     <= hold_d;
    end
  end

  // debounce period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  assign push_o      = take;
  assign push_word_o = relay_d;

endmodule

`default_nettype wire

[hw/rtl/dktr_fifo.sv]
// two-entry queue of relay words between front and back
`default_nettype none

module dktr_fifo import dktr_pkg::*; #(
  parameter int unsigned RELAY_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [RELAY_BITS-1:0] push_word_i,
  input  wire logic                  pop_i,
  output logic [RELAY_BITS-1:0]      pop_word_o,
  output q_stat_t                    stat_o
);

  logic [RELAY_BITS-1:0] mem_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign pop_word_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

`default_nettype wire

[hw/rtl/dktr_back.sv]
// back part: shifts each relay word out one bit per beat, lsb first
`default_nettype none

module dktr_back import dktr_pkg::*; #(
  parameter int unsigned RELAY_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire q_stat_t               q_stat_i,
  input  wire logic [RELAY_BITS-1:0] q_word_i,
  output logic                       pop_o,
  dktr_out_if.source                 bit_o
);

  localparam int unsigned CNT_W = $clog2(RELAY_BITS);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(RELAY_BITS - 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [RELAY_BITS-1:0] word_q;
  logic                  fire;
  logic                  at_last;

  // relay word shown on every beat, cut or widened to the port width
  function automatic logic [WORD_OUT_W-1:0] out_word(input logic [RELAY_BITS-1:0] v);
    logic [WORD_OUT_W-1:0] w;
    w = '0;
    for (int i = 0; i < int'(WORD_OUT_W); i++) begin
      if (i < int'(RELAY_BITS)) begin
        w[i] = v[i];
      end
    end
    return w;
  endfunction

  assign fire    = bit_o.valid && bit_o.ready;
  assign at_last = (cnt_q == LAST_IDX);
  assign pop_o   = !q_stat_i.empty && (!busy_q || (fire && at_last));

  // bit counter and word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (fire) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= q_word_i;
    end
  end

  // result beat drawn from the registers
  assign bit_o.valid      = busy_q;
  assign bit_o.serial_bit = word_q[cnt_q];
  assign bit_o.latch_last = at_last;
  assign bit_o.relay_word = out_word(word_q);

endmodule

`default_nettype wire
